// File: rtl/bt_pkg.sv
// ---------------------------------------------------------------------------
// bt_pkg: shared types and constants for the binomial tree pricer
// Payload structs, register indexes and reset values, and the command set
// that the sequencer broadcasts down the row of node cells.
// ---------------------------------------------------------------------------
package bt_pkg;

   localparam int VAL_W   = 32;
   localparam int STEP_W  = 7;
   localparam int INDEX_W = 3;

   localparam logic [VAL_W-1:0] ONE_Q31 = 32'h8000_0000;

   typedef enum logic [INDEX_W-1:0] {
      CSR_STEP_COUNT      = 3'd0,
      CSR_IS_PUT          = 3'd1,
      CSR_UP_FACTOR       = 3'd2,
      CSR_DOWN_FACTOR     = 3'd3,
      CSR_UP_PROBABILITY  = 3'd4,
      CSR_DISCOUNT_FACTOR = 3'd5
   } csr_index_type;

   localparam logic [STEP_W-1:0] RST_STEP_COUNT      = 7'd4;
   localparam logic              RST_IS_PUT          = 1'b0;
   localparam logic [VAL_W-1:0]  RST_UP_FACTOR       = 32'd1104966000;
   localparam logic [VAL_W-1:0]  RST_DOWN_FACTOR     = 32'd1043408000;
   localparam logic [VAL_W-1:0]  RST_UP_PROBABILITY  = 32'd1096700000;
   localparam logic [VAL_W-1:0]  RST_DISCOUNT_FACTOR = 32'd2145278000;

   typedef struct packed {
      logic [VAL_W-1:0] spot;
      logic [VAL_W-1:0] strike;
   } req_type;

   typedef struct packed {
      logic [VAL_W-1:0] option_value;
      logic             saturated;
   } rsp_type;

   typedef struct packed {
      logic [STEP_W-1:0] step_count;
      logic              is_put;
      logic [VAL_W-1:0]  up_factor;
      logic [VAL_W-1:0]  down_factor;
      logic [VAL_W-1:0]  up_probability;
      logic [VAL_W-1:0]  discount_factor;
   } cfg_type;

   // commands to the node cells
   typedef enum logic [2:0] {
      OP_HOLD   = 3'd0,
      OP_LOAD   = 3'd1,
      OP_LEAF   = 3'd2,
      OP_PAYOFF = 3'd3,
      OP_FOLD_A = 3'd4,
      OP_FOLD_B = 3'd5,
      OP_FOLD_C = 3'd6,
      OP_FINISH = 3'd7
   } op_type;

   typedef struct packed {
      op_type           op;
      logic             is_put;
      logic             first;
      logic [VAL_W-1:0] spot;
      logic [VAL_W-1:0] strike;
      logic [VAL_W-1:0] up_factor;
      logic [VAL_W-1:0] down_factor;
      logic [VAL_W-1:0] prob;
      logic [VAL_W-1:0] disc;
   } ctl_type;

   // what a cell shows its left neighbor
   typedef struct packed {
      logic [VAL_W-1:0] cur;
      logic [VAL_W-1:0] val;
      logic             sat;
   } link_type;

endpackage

// File: rtl/bt_cell.sv
// ---------------------------------------------------------------------------
// bt_cell: one node of the tree row
// Holds one node value with its own multiplier. Builds its leaf price by
// repeated multiplies, turns it into a payoff, then folds with the value of
// its right neighbor once per tree level, in fold steps A, B and C.
// ---------------------------------------------------------------------------
module bt_cell import bt_pkg::*; #(
   parameter int CW    = 7,
   parameter int INDEX = 0
) (
   input  logic          clock,
   input  ctl_type       ctl,
   input  logic [CW-1:0] lim,
   input  link_type      right,
   output link_type      left_out
);

   localparam logic [CW-1:0] IDX = CW'(INDEX);

   logic [VAL_W-1:0]   val_ff;
   logic               sat_ff;
   logic               active_ff;
   logic signed [65:0] prod_ff;
   logic [62:0]        acc_ff;

   logic [VAL_W-1:0]   cur;
   logic               use_up;
   logic signed [32:0] mul_a;
   logic signed [32:0] mul_b;
   logic signed [65:0] product;
   logic               leaf_sat;
   logic [VAL_W-1:0]   leaf_val;
   logic [VAL_W-1:0]   payoff;
   logic [65:0]        sum;

   always_comb begin
      // value of this level: fresh payoff on the first level, else last fold
      cur    = ctl.first ? val_ff : prod_ff[62:31];
      use_up = lim > IDX;
      mul_a  = '0;
      mul_b  = '0;
      case (ctl.op)
         OP_LEAF: begin
            mul_a = {1'b0, val_ff};
            mul_b = {1'b0, use_up ? ctl.up_factor : ctl.down_factor};
         end
         OP_FOLD_A: begin
            // p*upper + q*lower == lower*2^31 + p*(upper - lower)
            mul_a = $signed({1'b0, cur}) - $signed({1'b0, right.cur});
            mul_b = {1'b0, ctl.prob};
         end
         OP_FOLD_C: begin
            mul_a = {1'b0, acc_ff[62:31]};
            mul_b = {1'b0, ctl.disc};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      product  = mul_a * mul_b;
      leaf_sat = |product[63:62];
      leaf_val = leaf_sat ? '1 : product[61:30];
      if (ctl.is_put) begin
         payoff = (ctl.strike > val_ff) ? ctl.strike - val_ff : '0;
      end else begin
         payoff = (val_ff > ctl.strike) ? val_ff - ctl.strike : '0;
      end
      sum = 66'({right.val, 31'b0}) + prod_ff;
   end

   always_ff @(posedge clock) begin
      case (ctl.op)
         OP_LOAD: begin
            val_ff    <= ctl.spot;
            sat_ff    <= 1'b0;
            active_ff <= IDX <= lim;
         end
         OP_LEAF: begin
            if (active_ff) begin
               val_ff <= leaf_val;
               sat_ff <= sat_ff | leaf_sat;
            end
         end
         OP_PAYOFF: val_ff <= payoff;
         OP_FOLD_A: begin
            val_ff  <= cur;
            prod_ff <= product;
         end
         OP_FOLD_B: begin
            acc_ff <= sum[62:0];
            // gather clip flags toward the root
            sat_ff <= sat_ff | right.sat;
         end
         OP_FOLD_C: prod_ff <= product;
         OP_FINISH: val_ff  <= prod_ff[62:31];
         default: begin
         end
      endcase
   end

   assign left_out.cur = cur;
   assign left_out.val = val_ff;
   assign left_out.sat = sat_ff;

endmodule

// File: rtl/bt_ctrl.sv
// ---------------------------------------------------------------------------
// bt_ctrl: sequencer for the tree row
// Takes a request beat, then steps the cells through leaf build, payoff,
// the backward levels and the result strobe.
// ---------------------------------------------------------------------------
module bt_ctrl import bt_pkg::*; #(
   parameter int MAX_STEPS = 64,
   parameter int CW        = $clog2(MAX_STEPS + 1)
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   output logic          busy,
   input  req_type       req_payload,
   input  cfg_type       cfg,
   output ctl_type       ctl,
   output logic [CW-1:0] lim,
   output logic          strobe
);

   localparam int SW = (CW > STEP_W) ? CW : STEP_W;

   typedef enum logic [7:0] {
      ST_IDLE   = 8'b0000_0001,
      ST_LEAF   = 8'b0000_0010,
      ST_PAYOFF = 8'b0000_0100,
      ST_FOLD_A = 8'b0000_1000,
      ST_FOLD_B = 8'b0001_0000,
      ST_FOLD_C = 8'b0010_0000,
      ST_FINISH = 8'b0100_0000,
      ST_RESULT = 8'b1000_0000
   } state_type;

   state_type        state_ff, state_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic [CW-1:0]    n_ff, n_in;
   logic             first_ff, first_in;
   logic [VAL_W-1:0] strike_ff, strike_in;

   logic [SW-1:0]    step_ext;
   logic [CW-1:0]    n_eff;
   logic             accept;

   always_comb begin
      step_ext = SW'(cfg.step_count);
      n_eff    = (step_ext > SW'(MAX_STEPS)) ? CW'(MAX_STEPS) : CW'(step_ext);
      busy     = state_ff != ST_IDLE;
      accept   = start && !busy;
      strobe   = state_ff == ST_RESULT;

      state_in  = state_ff;
      cnt_in    = cnt_ff;
      n_in      = n_ff;
      first_in  = first_ff;
      strike_in = strike_ff;
      ctl.op    = OP_HOLD;
      lim       = cnt_ff;

      case (state_ff)
         ST_IDLE: begin
            lim = n_eff;
            if (accept) begin
               ctl.op    = OP_LOAD;
               strike_in = req_payload.strike;
               cnt_in    = n_eff;
               n_in      = n_eff;
               state_in  = (n_eff == '0) ? ST_PAYOFF : ST_LEAF;
            end
         end
         ST_LEAF: begin
            ctl.op = OP_LEAF;
            cnt_in = cnt_ff - CW'(1);
            if (cnt_ff == CW'(1)) begin
               state_in = ST_PAYOFF;
            end
         end
         ST_PAYOFF: begin
            ctl.op   = OP_PAYOFF;
            cnt_in   = n_ff;
            first_in = 1'b1;
            state_in = (n_ff == '0) ? ST_RESULT : ST_FOLD_A;
         end
         ST_FOLD_A: begin
            ctl.op   = OP_FOLD_A;
            state_in = ST_FOLD_B;
         end
         ST_FOLD_B: begin
            ctl.op   = OP_FOLD_B;
            state_in = ST_FOLD_C;
         end
         ST_FOLD_C: begin
            ctl.op   = OP_FOLD_C;
            first_in = 1'b0;
            if (cnt_ff == CW'(1)) begin
               state_in = ST_FINISH;
            end else begin
               cnt_in   = cnt_ff - CW'(1);
               state_in = ST_FOLD_A;
            end
         end
         ST_FINISH: begin
            ctl.op   = OP_FINISH;
            state_in = ST_RESULT;
         end
         ST_RESULT: state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase

      ctl.is_put      = cfg.is_put;
      ctl.first       = first_ff;
      ctl.spot        = req_payload.spot;
      ctl.strike      = strike_ff;
      ctl.up_factor   = cfg.up_factor;
      ctl.down_factor = cfg.down_factor;
      ctl.prob        = (cfg.up_probability > ONE_Q31) ? ONE_Q31 : cfg.up_probability;
      ctl.disc        = (cfg.discount_factor > ONE_Q31) ? ONE_Q31 : cfg.discount_factor;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         n_ff     <= '0;
         first_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         n_ff     <= n_in;
         first_ff <= first_in;
      end
      strike_ff <= strike_in;
   end

endmodule

// File: rtl/binomial_tree_option_pricer.sv
// ---------------------------------------------------------------------------
// binomial_tree_option_pricer: European call/put on a recombining tree
// A row of MAX_STEPS+1 node cells, each with its own multiplier, builds the
// leaf prices in parallel and folds the tree back one level at a time.
//
//   channel   handshake                 payload
//   request   start / busy              req_payload (spot, strike)
//   result    strobe, one cycle         rsp_payload (option_value, saturated)
//   config    csr_write_enable          csr_index, csr_data
//
// With n = min(step_count, MAX_STEPS), a request runs n leaf multiplies,
// a payoff step, n backward levels of fold steps A, B and C in each cell's
// multiplier, a finish step and the strobe (n = 0: payoff, then strobe).
// busy rises after the accepted beat and stays high through the strobe cycle.
// Reset returns the sequencer to idle and the registers to their defaults;
// node values need no clearing. The result beat cannot be stalled.
// ---------------------------------------------------------------------------
module binomial_tree_option_pricer import bt_pkg::*; #(
   parameter int MAX_STEPS = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  req_type            req_payload,
   output logic               strobe,
   output rsp_type            rsp_payload,
   input  logic               csr_write_enable,
   input  logic [INDEX_W-1:0] csr_index,
   input  logic [VAL_W-1:0]   csr_data
);

   localparam int CW = $clog2(MAX_STEPS + 1);

   cfg_type       cfg_ff;
   ctl_type       ctl;
   logic [CW-1:0] lim;
   link_type      links [0:MAX_STEPS+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.step_count      <= RST_STEP_COUNT;
         cfg_ff.is_put          <= RST_IS_PUT;
         cfg_ff.up_factor       <= RST_UP_FACTOR;
         cfg_ff.down_factor     <= RST_DOWN_FACTOR;
         cfg_ff.up_probability  <= RST_UP_PROBABILITY;
         cfg_ff.discount_factor <= RST_DISCOUNT_FACTOR;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_STEP_COUNT:      cfg_ff.step_count      <= csr_data[STEP_W-1:0];
            CSR_IS_PUT:          cfg_ff.is_put          <= csr_data[0];
            CSR_UP_FACTOR:       cfg_ff.up_factor       <= csr_data;
            CSR_DOWN_FACTOR:     cfg_ff.down_factor     <= csr_data;
            CSR_UP_PROBABILITY:  cfg_ff.up_probability  <= csr_data;
            CSR_DISCOUNT_FACTOR: cfg_ff.discount_factor <= csr_data;
            default: begin
               // drop writes past the register list
            end
         endcase
      end
   end

   bt_ctrl #(
      .MAX_STEPS (MAX_STEPS),
      .CW        (CW)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .cfg         (cfg_ff),
      .ctl         (ctl),
      .lim         (lim),
      .strobe      (strobe)
   );

   // nothing to the right of the last cell
   assign links[MAX_STEPS+1] = '0;

   for (genvar i = 0; i <= MAX_STEPS; i++) begin : g_cell
      bt_cell #(
         .CW    (CW),
         .INDEX (i)
      ) u_cell (
         .clock    (clock),
         .ctl      (ctl),
         .lim      (lim),
         .right    (links[i+1]),
         .left_out (links[i])
      );
   end

   assign rsp_payload.option_value = links[0].val;
   assign rsp_payload.saturated    = links[0].sat;

endmodule
